// ----- rtl/core/decimal_text_to_fixed_point_top_defines.svh -----
// Assertion macros shared by the checker.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define DTFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtfp check failed");

// Consequent checked in the same cycle as the antecedent.
`define DTFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtfp check failed");

`endif

// ----- rtl/core/dtfp_pkg.sv -----
package dtfp_pkg;

  localparam int CHAR_W              = 8;
  localparam int VAL_W               = 64;
  localparam int FD_W                = 5;
  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 19;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    CS_PARSE,
    CS_DIVIDE,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;   // parse one character
    logic start;  // terminator: load divider, clear parse state
    logic step;   // one quotient bit
    logic load;   // write result register
  } dp_cmd_t;

  typedef struct packed {
    logic term;   // character on the input is the terminator
    logic last;   // this divider step is the final one
  } dp_status_t;

  // 10^n, capped at 10^19
  function automatic logic [VAL_W-1:0] pow10(input logic [FD_W-1:0] n);
    logic [VAL_W-1:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd10000000000000000000;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/decimal_text_to_fixed_point_top.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------
// in       | in_valid / in_ready   | character[7:0], one byte per beat
// out      | out_valid / out_ready | value[63:0] signed Q31.32, overflow
//
// A non-zero character is taken whenever offered; in_ready stays high while parsing.
// The zero byte starts a one-bit-per-cycle restoring divider, one step per
// quotient bit, then the result register is written once it is free; in_ready
// stays low until then.
// rst is synchronous: parse state cleared, no result pending.
// A result waiting on out_ready does not block parsing; only a second
// terminator's result waits in the finish state until the register frees.
module decimal_text_to_fixed_point_top
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHAR_W-1:0]       character,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] value,
  output logic                    overflow
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: parse, divide, write result
  dtfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // parse registers, divider and result register
  dtfp_datapath #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .overflow  (overflow)
  );

endmodule

// ----- rtl/core/dtfp_ctrl.sv -----
module dtfp_ctrl
  import dtfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        can_load;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_PARSE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CS_PARSE:  if (in_valid && status.term) state_next = CS_DIVIDE;
      CS_DIVIDE: if (status.last) state_next = CS_FINISH;
      CS_FINISH: if (can_load) state_next = CS_PARSE;
      default:   state_next = CS_PARSE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      CS_PARSE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = status.term;
          cmd.take  = !status.term;
        end
      end
      CS_DIVIDE: cmd.step = 1'b1;
      CS_FINISH: cmd.load = can_load;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = (out_valid && !out_ready) || cmd.load;
  end

endmodule

// ----- rtl/core/dtfp_datapath.sv -----
module dtfp_datapath
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CHAR_W-1:0]       character,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic signed [VAL_W-1:0] value,
  output logic                    overflow
);

  localparam int QW    = VAL_W + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  // parse state
  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [VAL_W-1:0]   mantissa, mantissa_next;
  logic               point_seen, point_seen_next;
  logic [FD_W-1:0]    fraction_digits, fraction_digits_next;
  logic               saturated, saturated_next;

  // divider
  logic [VAL_W-1:0]   rem, den;
  logic [QW-1:0]      quo;
  logic [CNT_W-1:0]   cnt;
  logic               neg_h, sat_h;
  logic [VAL_W:0]     trial, diff;
  logic               ge;

  logic               do_char, is_digit;
  logic [VAL_W+3:0]   accum;
  logic               too_big, exact_min;
  logic [VAL_W-1:0]   mag;

  assign status.term = (character == CH_NUL);
  assign status.last = (cnt == CNT_W'(QW - 1));

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  // m*10 + d as shift-add, four guard bits catch overflow
  assign accum = ({4'b0, mantissa} << 3) + ({4'b0, mantissa} << 1)
               + {{(VAL_W){1'b0}}, character[3:0]};

  always_comb begin
    phase_next           = phase;
    negative_next        = negative;
    mantissa_next        = mantissa;
    point_seen_next      = point_seen;
    fraction_digits_next = fraction_digits;
    saturated_next       = saturated;
    do_char              = 1'b0;
    if (cmd.start) begin
      phase_next           = PH_SPACES;
      negative_next        = 1'b0;
      mantissa_next        = '0;
      point_seen_next      = 1'b0;
      fraction_digits_next = '0;
      saturated_next       = 1'b0;
    end else if (cmd.take) begin
      case (phase)
        PH_SPACES: begin
          if (character != CH_SPACE) begin
            phase_next = PH_DIGITS;
            if (character == CH_MINUS) begin
              negative_next = 1'b1;
            end else if (character != CH_PLUS) begin
              do_char = 1'b1;
            end
          end
        end
        PH_DIGITS: do_char = 1'b1;
        default: ;
      endcase
    end
    if (do_char) begin
      if (is_digit) begin
        if (point_seen && (fraction_digits >= FD_W'(MAX_FRAC_DIGITS))) begin
          saturated_next = 1'b1;
        end else begin
          if (point_seen) begin
            fraction_digits_next = fraction_digits + FD_W'(1);
          end
          if (|accum[VAL_W+3:VAL_W]) begin
            mantissa_next  = '1;
            saturated_next = 1'b1;
          end else begin
            mantissa_next = accum[VAL_W-1:0];
          end
        end
      end else if (character == CH_POINT) begin
        point_seen_next = 1'b1;
      end else begin
        phase_next = PH_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SPACES;
      negative        <= 1'b0;
      mantissa        <= '0;
      point_seen      <= 1'b0;
      fraction_digits <= '0;
      saturated       <= 1'b0;
    end else begin
      phase           <= phase_next;
      negative        <= negative_next;
      mantissa        <= mantissa_next;
      point_seen      <= point_seen_next;
      fraction_digits <= fraction_digits_next;
      saturated       <= saturated_next;
    end
  end

  // restoring division of {mantissa, FRAC_BITS zeros} by 10^digits
  assign trial = {rem, quo[QW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = !diff[VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem   <= '0;
      quo   <= {mantissa, {(FRAC_BITS){1'b0}}};
      den   <= pow10(fraction_digits);
      cnt   <= '0;
      neg_h <= negative;
      sat_h <= saturated;
    end else if (cmd.step) begin
      rem <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      quo <= {quo[QW-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // range check: quotient must fit in 63 bits, -2^63 allowed exactly
  assign too_big   = |quo[QW-1:VAL_W-1];
  assign exact_min = quo[VAL_W-1] && !(|quo[QW-1:VAL_W]) && !(|quo[VAL_W-2:0]);

  always_comb begin
    if (too_big) begin
      mag = (neg_h) ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      mag = {1'b0, quo[VAL_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value    <= $signed(neg_h ? (VAL_W'(0) - mag) : mag);
      overflow <= sat_h || (too_big && !(neg_h && exact_min));
    end
  end

endmodule

// ----- rtl/core/dtfp_checker.sv -----
`include "decimal_text_to_fixed_point_top_defines.svh"

module dtfp_checker
  import dtfp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CHAR_W-1:0] character,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VAL_W-1:0]  value,
  input logic              overflow
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // stalled result holds
  `DTFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({value, overflow}))

  // terminator stops intake while dividing
  `DTFP_ASSERT_NEXT(a_term_busy, in_beat && (character == CH_NUL), !in_ready)

  // a new result appears only after a busy cycle
  `DTFP_ASSERT_SAME(a_rose_busy, $rose(out_valid), !$past(in_ready))

  // an ordinary character never yields a result
  `DTFP_ASSERT_NEXT(a_no_spurious, in_beat && (character != CH_NUL) && !out_valid, !out_valid)

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_chk (.*);

// ----- sim/decimal_text_to_fixed_point_checker.sv -----
module decimal_text_to_fixed_point_checker
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CHAR_W-1:0]       character,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    overflow,
  output int                      mismatches,
  output int                      results_due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    overflow;
  } fixed_result_t;

  fixed_result_t results_due[$];

  // Parse state of the string in flight
  phase_t           phase;
  logic             negative;
  logic [VAL_W-1:0] mantissa;
  logic             point_seen;
  logic [FD_W-1:0]  fraction_digits;
  logic             saturated;

  initial mismatches = 0;
  initial results_due_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_parse();
    phase           = PH_SPACES;
    negative        = 1'b0;
    mantissa        = '0;
    point_seen      = 1'b0;
    fraction_digits = '0;
    saturated       = 1'b0;
  endtask

  // mantissa / 10^fraction_digits as signed fixed point, magnitude truncated
  function automatic fixed_result_t scaled_result();
    fixed_result_t    res;
    logic [VAL_W-1:0] divisor;
    logic [VAL_W-1:0] whole;
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] frac;
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] limit;
    logic             carry;
    logic             over;
    int               i;
    divisor = 64'd1;
    frac    = '0;
    over    = 1'b0;
    for (i = 0; i < fraction_digits && i < 19; i++) divisor = divisor * 64'd10;
    whole = mantissa / divisor;
    rem   = mantissa % divisor;
    // long division for the fraction bits; carry covers remainders past 2^63
    for (i = 0; i < FRAC_BITS; i++) begin
      carry = rem[VAL_W-1];
      rem   = rem << 1;
      frac  = frac << 1;
      if (carry || rem >= divisor) begin
        rem     = rem - divisor;
        frac[0] = 1'b1;
      end
    end
    limit = 64'd1 << (63 - FRAC_BITS);
    if (whole >= limit) begin
      if (negative && whole == limit && frac == '0) begin
        mag = 64'h8000_0000_0000_0000;   // exactly the most negative value
      end else begin
        over = 1'b1;
        mag  = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end else begin
      mag = (whole << FRAC_BITS) | frac;
    end
    res.value    = negative ? (64'd0 - mag) : mag;
    res.overflow = saturated || over;
    return res;
  endfunction

  task automatic accumulate(input logic [CHAR_W-1:0] ch);
    logic [VAL_W-1:0] digit;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      digit = VAL_W'(ch - CH_ZERO);
      if (point_seen && fraction_digits >= MAX_FRAC_DIGITS) begin
        saturated = 1'b1;   // surplus fraction digit dropped
      end else begin
        if (point_seen) fraction_digits++;
        if (mantissa > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10) begin
          mantissa  = '1;
          saturated = 1'b1;
        end else begin
          mantissa = mantissa * 64'd10 + digit;
        end
      end
    end else if (ch == CH_POINT) begin
      point_seen = 1'b1;
    end else begin
      phase = PH_STOPPED;
    end
  endtask

  task automatic take_character(input logic [CHAR_W-1:0] ch);
    if (ch == CH_NUL) begin
      results_due.push_back(scaled_result());
      clear_parse();
    end else begin
      case (phase)
        PH_SPACES: begin
          if (ch != CH_SPACE) begin
            phase = PH_DIGITS;
            if (ch == CH_MINUS) negative = 1'b1;
            else if (ch != CH_PLUS) accumulate(ch);
          end
        end
        PH_DIGITS: begin
          accumulate(ch);
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_result();
    fixed_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result with none due: value=%0d overflow=%0b",
                                value, overflow));
      return;
    end
    want = results_due.pop_front();
    if (value !== want.value)
      report_mismatch($sformatf("value %0d, predicted %0d", value, want.value));
    if (overflow !== want.overflow)
      report_mismatch($sformatf("overflow %0b, predicted %0b", overflow, want.overflow));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_character(character);
    end
    results_due_count <= results_due.size();
  end

endmodule

// ----- sim/decimal_text_to_fixed_point_top_test.sv -----
module decimal_text_to_fixed_point_top_test
  import dtfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Character beats to send before the random part stops (space bytes
  // are not counted; the block simply skips leading ones).
  localparam int TOTAL_BEATS  = 1050;
  // Drain allows twice the time a terminator costs.
  localparam int DRAIN_CYCLES = 2 * (66 + FRAC_BITS_DEF);
  localparam int CYCLE_LIMIT  = 400_000;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [CHAR_W-1:0]       character = CH_NUL;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] value;
  logic                    overflow;

  int mismatches;
  int results_due_count;
  int tx_idle_pct = 22;   // chance in a hundred that the sender inserts an idle, redrawn after each idle
  int rx_idle_pct = 74;   // same for the receiver holding out_ready low
  int beats_sent  = 0;
  int cycle_count = 0;

  logic [CHAR_W-1:0] text_q[$];   // string under construction, no terminator

  // Strings that sit on the Q31.32 limits, the 64-bit mantissa limit or the fraction digit limit
  string boundary_texts[10] = '{
    "2147483648",
    "2147483647.99999999999",
    "2147483647.9999999999999999999",
    "18446744073709551615",
    "18446744073709551616",
    "0.0000000001",
    "0.0000000000000000001",
    "0.00000000000000000009",
    "1.0000000000000000001",
    "9999999999999999999.9"
  };

  decimal_text_to_fixed_point_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .overflow  (overflow)
  );

  decimal_text_to_fixed_point_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .character         (character),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .value             (value),
    .overflow          (overflow),
    .mismatches        (mismatches),
    .results_due_count (results_due_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: out_ready is redrawn every cycle at the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("decimal_text_to_fixed_point_top verification failed");
    $finish;
  end

  // One beat on the input channel. Idle cycles come first, with valid low;
  // once raised, valid and the byte hold until the beat is taken.
  task automatic send_beat(input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= ch;
    do @(posedge clk); while (!in_ready);
    if (ch != CH_SPACE) beats_sent++;
  endtask

  // Sends text_q followed by the terminating zero byte.
  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i]);
    send_beat(CH_NUL);
  endtask

  task automatic append_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_literal(input string s);
    text_q.delete();
    append_text(s);
    send_text();
  endtask

  task automatic append_digits(input int count);
    repeat (count) text_q.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
  endtask

  // Builds one random string. Mostly well-formed numbers of varied length,
  // some long enough to overflow the mantissa or the fraction digit count,
  // some at the range limits, the rest noise or numbers with a stray byte.
  task automatic compose_string();
    int kind;
    int spaces;
    int int_digits;
    int frac_digits;
    logic [CHAR_W-1:0] glitch;
    text_q.delete();
    kind   = $urandom_range(99);
    spaces = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (spaces) text_q.push_back(CH_SPACE);
    case ($urandom_range(3))
      0: begin
        text_q.push_back(CH_MINUS);
      end
      1: begin
        text_q.push_back(CH_PLUS);
      end
      default: ;
    endcase
    if (kind < 10) begin
      // noise: any non-zero bytes, top bit included
      repeat ($urandom_range(1, 8)) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
    end else if (kind < 22) begin
      append_text(boundary_texts[$urandom_range(9)]);
    end else begin
      int_digits = (kind < 32) ? $urandom_range(18, 24) : $urandom_range(0, 11);
      if ($urandom_range(1) == 0) begin
        frac_digits = -1;
      end else if ($urandom_range(4) == 0) begin
        frac_digits = $urandom_range(18, 23);
      end else begin
        frac_digits = $urandom_range(0, 10);
      end
      append_digits(int_digits);
      if (frac_digits >= 0) begin
        text_q.push_back(CH_POINT);
        append_digits(frac_digits);
      end
      // broken sequence: one stray byte somewhere in the number
      if (kind >= 88) begin
        case ($urandom_range(4))
          0:       glitch = CH_POINT;
          1:       glitch = CH_PLUS;
          2:       glitch = CH_MINUS;
          3:       glitch = CH_SPACE;
          default: glitch = CHAR_W'($urandom_range(1, 255));
        endcase
        text_q.insert($urandom_range(0, text_q.size()), glitch);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: negative zero behind a space, a doubled sign, a
    // space after the sign, repeated points, an empty string, a byte with
    // the top bit set stopping the parse, and a lone point.
    send_literal(" -0");
    send_literal("+-1");
    send_literal("- 9");
    send_literal("1.2.5");
    send_literal("");
    text_q.delete();
    text_q.push_back(8'hFF);
    append_text("7");
    send_text();
    send_literal(".");

    // Random strings; the idle pattern flips a third of the way in and
    // stops altogether for the final third.
    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent >= 2 * TOTAL_BEATS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end else if (beats_sent >= TOTAL_BEATS / 3) begin
        tx_idle_pct = 74;
        rx_idle_pct <= 22;
      end
      compose_string();
      send_text();
    end
    in_valid <= 1'b0;

    // Let the checker see the last beat, then wait for every result.
    @(posedge clk);
    while (results_due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due_count == 0) begin
      $display("decimal_text_to_fixed_point_top verification clean");
    end else begin
      $display("decimal_text_to_fixed_point_top verification failed");
    end
    $finish;
  end

endmodule
